>>> rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    // field widths
    localparam int VALUE_W = 64;
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;

    // BCD register must hold the longest 64-bit unsigned value (20 digits)
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int LEN_W      = $clog2(BCD_DIGITS + 1);

    // one shift-and-adjust step per magnitude bit
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    // decoupling queue between front and back
    localparam int Q_DEPTH = 2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // number kinds; the unused code is handled as unsigned 64-bit
    typedef enum logic [KIND_W-1:0] {
        KIND_S32 = 2'd0,
        KIND_S64 = 2'd1,
        KIND_U64 = 2'd2
    } t_kind;

    // classified item: sign flag and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back-end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/i2da_front.sv
// ----------------------------------------------------------------------------
// i2da_front
// Accepts input transactions and splits each value into sign and magnitude.
// ----------------------------------------------------------------------------
module i2da_front import i2da_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [KIND_W-1:0]  i_kind,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_item              o_item
);

    logic [31:0] low;

    // take a transaction whenever the queue has room
    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;
    assign low     = i_value[31:0];

    // sign and magnitude; most negative values stay exact as unsigned
    always_comb begin
        o_item = '0;
        unique case (i_kind)
            KIND_S32: begin
                o_item.neg = low[31];
                o_item.mag = low[31] ? {32'd0, (~low) + 32'd1} : {32'd0, low};
            end
            KIND_S64: begin
                o_item.neg = i_value[VALUE_W-1];
                o_item.mag = i_value[VALUE_W-1] ? (~i_value) + VALUE_W'(1) : i_value;
            end
            default: begin
                o_item.neg = 1'b0;
                o_item.mag = i_value;
            end
        endcase
    end

    // a negative item never carries a zero magnitude
    a_neg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_item.neg |-> o_item.mag != '0)
        else $error("negative item with zero magnitude");

endmodule

>>> rtl/i2da_fifo.sv
// ----------------------------------------------------------------------------
// i2da_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module i2da_fifo import i2da_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/i2da_back.sv
// ----------------------------------------------------------------------------
// i2da_back
// Double-dabble conversion of one magnitude, then character emission
// through an output register.
// ----------------------------------------------------------------------------
module i2da_back import i2da_pkg::*; #(
    parameter int MAX_DIGITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_stat           i_q_stat,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [BCD_W-1:0]    adj;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_neg, n_neg;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [3:0]          r_dig [MAX_DIGITS];
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    nd;
    logic [LEN_W-1:0]    nd_m1;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_char;
    logic                r_out_last, n_last;
    logic                out_free;
    logic                out_load;

    // add 3 to every digit of 5 or more ahead of the shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (b[i*4 +: 4] >= 4'd5) begin
                r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // every digit in decimal range
    function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (b[i*4 +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign adj      = bcd_adjust(r_bcd);
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_char   = r_out_char;
    assign o_last   = r_out_last;

    // significant digit count, clipped to the digit store; zero keeps one digit
    always_comb begin
        len = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                len = LEN_W'(i + 1);
            end
        end
        if (len == '0) begin
            nd = LEN_W'(1);
        end else if (len > LEN_W'(MAX_DIGITS)) begin
            nd = LEN_W'(MAX_DIGITS);
        end else begin
            nd = len;
        end
        nd_m1 = nd - LEN_W'(1);
    end

    // sequencer: next state, datapath and output load
    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_step   = r_step;
        n_neg    = r_neg;
        n_idx    = r_idx;
        n_char   = r_out_char;
        n_last   = r_out_last;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_bin   = i_item.mag;
                    n_neg   = i_item.neg;
                    n_bcd   = '0;
                    n_step  = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_idx   = nd_m1[IDX_W-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_neg) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = CHAR_ZERO + {4'd0, r_dig[r_idx]};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_step     <= n_step;
        r_neg      <= n_neg;
        r_idx      <= n_idx;
        r_out_char <= n_char;
        r_out_last <= n_last;
    end

    // digit store keeps the least significant digits
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LEN) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_dig[i] <= r_bcd[i*4 +: 4];
            end
        end
    end

    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CONV |-> bcd_ok(r_bcd))
        else $error("BCD digit out of range during conversion");

    a_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> r_state == ST_EMIT)
        else $error("character loaded outside emission");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && n_last |=> r_state == ST_IDLE)
        else $error("final character without return to idle");

endmodule

>>> rtl/integer_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit
// Converts a 64-bit integer pattern to decimal ASCII text, one character per
// output transaction, most significant digit first.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries the raw value, s_axis_tuser the kind
// (signed 32-bit, signed 64-bit, unsigned 64-bit; the spare code is unsigned).
// Output stream: one transaction per character, '-' first for negative
// values, a lone '0' for zero; m_axis_tlast marks the final character.
// The first character follows the input transaction through the queue pop,
// 64 shift-and-adjust steps and one length step.
// Numbers are converted one at a time by the 64-step double-dabble loop,
// then emitted one character a cycle while the receiver is ready, through
// the single output register.
// A two-entry queue sits between input classification and conversion, so
// up to two further numbers are taken while one is being converted.
// A stalled receiver holds the current character; emission and then
// conversion pause behind it, and input is refused once the queue is full.
// Reset (synchronous, active low) empties the queue and the output register.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit import i2da_pkg::*; #(
    parameter int MAX_DIGITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value_bits
    input  logic [1:0]  s_axis_tuser,   // [1:0] number_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] ascii_char
    output logic        m_axis_tlast    // last_char
);

    t_q_stat q_stat;
    t_item   push_item;
    t_item   head_item;
    logic    push;
    logic    pop;

    // classify and enqueue
    i2da_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_value  (s_axis_tdata),
        .i_kind   (s_axis_tuser),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_item   (push_item)
    );

    // decoupling queue
    i2da_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    // convert and emit
    i2da_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_char   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule
